// File: rtl/dos_pkg.sv
// Shared constants, types and helper functions of the diffserv output scheduler.
package dos_pkg;

	localparam int NUM_QUEUES      = 7;
	localparam int QUEUE_W         = 3;
	localparam int WEIGHTED_QUEUES = 6;
	localparam int WQ_IDX_W        = $clog2(WEIGHTED_QUEUES);
	localparam int WEIGHT_W        = 16;
	localparam int CUM_W           = WEIGHT_W + $clog2(WEIGHTED_QUEUES);
	localparam int LFSR_W          = 32;
	localparam int TIME_W          = 48;
	localparam int MAX_TRIES       = 50;
	localparam int TRY_W           = $clog2(MAX_TRIES + 1);
	localparam int REASON_W        = 3;
	localparam int CFG_INDEX_W     = 3;
	localparam int CFG_DATA_W      = 32;
	localparam int DIV_CNT_W       = $clog2(LFSR_W);

	localparam logic [QUEUE_W-1:0] Q_BE     = 3'd4;
	localparam logic [QUEUE_W-1:0] Q_NC     = 3'd5;
	localparam logic [QUEUE_W-1:0] Q_EF     = 3'd6;
	localparam logic [QUEUE_W-1:0] NO_QUEUE = 3'd7;

	localparam logic [CFG_INDEX_W-1:0] REG_RANDOM_SEED = 3'd6;

	localparam logic [LFSR_W-1:0] LFSR_TAPS  = 32'h8020_0003;
	localparam logic [LFSR_W-1:0] LFSR_RESET = 32'h0000_0001;

	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET [WEIGHTED_QUEUES] =
		'{16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1};

	typedef enum logic [REASON_W-1:0] {
		RSN_EF       = 3'd0,
		RSN_CONT     = 3'd1,
		RSN_RANDOM   = 3'd2,
		RSN_FALLBACK = 3'd3,
		RSN_SWAP     = 3'd4
	} reason_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rem_stat_t;

	// Galois right-shift step of the selection LFSR.
	function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
		logic [LFSR_W-1:0] n;
		n = s >> 1;
		if (s[0]) begin
			n = n ^ LFSR_TAPS;
		end
		return n;
	endfunction

	// Running sum of the reset weights up to and including entry idx.
	function automatic logic [CUM_W-1:0] cum_reset(input int idx);
		logic [CUM_W-1:0] sum;
		sum = '0;
		for (int i = 0; i < WEIGHTED_QUEUES; i++) begin
			if (i <= idx) begin
				sum = sum + CUM_W'(WEIGHT_RESET[i]);
			end
		end
		return sum;
	endfunction

endpackage

// File: rtl/dos_if.sv
// Request and response channel interfaces of the diffserv output scheduler.
interface dos_req_if;
	logic                           valid;
	logic                           ready;
	logic [dos_pkg::NUM_QUEUES-1:0] nonempty_mask;
	logic [dos_pkg::TIME_W-1:0]     besteffort_head_time;
	logic [dos_pkg::TIME_W-1:0]     netcontrol_head_time;

	modport source (
		output valid, nonempty_mask, besteffort_head_time, netcontrol_head_time,
		input  ready
	);
	modport sink (
		input  valid, nonempty_mask, besteffort_head_time, netcontrol_head_time,
		output ready
	);
endinterface

interface dos_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [dos_pkg::QUEUE_W-1:0]  served_queue;
	logic [dos_pkg::REASON_W-1:0] pick_reason;

	modport source (
		output valid, served_queue, pick_reason,
		input  ready
	);
	modport sink (
		input  valid, served_queue, pick_reason,
		output ready
	);
endinterface

// File: rtl/diffserv_output_scheduler_unit.sv
// Top level of the diffserv output scheduler: sequencer, LFSR and result register.
// Order: EF, continued and zero-weight decisions pass from the request transfer
//   through the decide state to the emit state, which loads the result register.
// Random draws: each draw runs the remainder unit one bit per cycle over the 32-bit
//   LFSR value, then checks the drawn queue; up to 50 draws, then the fallback scan.
// Throughput: one request at a time; the next is taken once the result is loaded or no queue is picked.
// Reset: no current queue, LFSR = 1, weights AF 0 and BE/NC 1, result register empty.
module diffserv_output_scheduler_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [dos_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [dos_pkg::CFG_DATA_W-1:0]   cfg_data,
	dos_req_if.sink                          req,
	dos_rsp_if.source                        rsp
);

	// One-hot sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_DECIDE = 4'b0010,
		ST_DIVIDE = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	state_t                          state_q;
	logic [dos_pkg::NUM_QUEUES-1:0]  mask_q;
	logic                            nc_earlier_q;
	logic [dos_pkg::QUEUE_W-1:0]     cur_q;
	logic [dos_pkg::LFSR_W-1:0]      lfsr_q;
	logic [dos_pkg::TRY_W-1:0]       try_q;
	logic [dos_pkg::QUEUE_W-1:0]     pick_q;
	dos_pkg::reason_t                reason_q;
	logic                            out_valid_q;
	logic [dos_pkg::QUEUE_W-1:0]     out_queue_q;
	dos_pkg::reason_t                out_reason_q;

	logic [dos_pkg::LFSR_W-1:0]      lfsr_nxt;
	logic [dos_pkg::NUM_QUEUES:0]    mask_ext;
	logic                            cur_hit;
	logic                            draw_hit;
	logic                            last_try;
	logic                            fb_found;
	logic [dos_pkg::QUEUE_W-1:0]     fb_queue;
	logic [dos_pkg::QUEUE_W-1:0]     fb_fin_queue;
	dos_pkg::reason_t                fb_fin_reason;
	logic [dos_pkg::QUEUE_W-1:0]     rnd_fin_queue;
	dos_pkg::reason_t                rnd_fin_reason;
	logic                            rem_start;
	logic [dos_pkg::CUM_W-1:0]       remainder;
	dos_pkg::rem_stat_t              rem_stat;
	logic [dos_pkg::CUM_W-1:0]       total;
	logic [dos_pkg::QUEUE_W-1:0]     draw_queue;

	// Weight table: cumulative sums and the mapping of a draw to a queue.
	dos_wtab u_wtab (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.draw       (remainder),
		.total      (total),
		.draw_queue (draw_queue)
	);

	// Shared remainder unit: LFSR value modulo the total weight, one bit a cycle.
	dos_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start),
		.dividend  (lfsr_nxt),
		.divisor   (total),
		.remainder (remainder),
		.stat      (rem_stat)
	);

	assign lfsr_nxt = dos_pkg::lfsr_step(lfsr_q);

	// Pad the mask with a zero so that "no queue" indexes an empty bit.
	assign mask_ext = {1'b0, mask_q};
	assign cur_hit  = mask_ext[cur_q];
	assign draw_hit = mask_ext[draw_queue];
	assign last_try = try_q == dos_pkg::TRY_W'(dos_pkg::MAX_TRIES - 1);

	// Fallback scan: lowest-numbered non-empty weighted queue.
	always_comb begin
		fb_found = 1'b0;
		fb_queue = dos_pkg::NO_QUEUE;
		for (int i = dos_pkg::WEIGHTED_QUEUES - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				fb_found = 1'b1;
				fb_queue = dos_pkg::QUEUE_W'(i);
			end
		end
	end

	// A best-effort pick moves to network control when NC holds a strictly older head.
	always_comb begin
		fb_fin_queue   = fb_queue;
		fb_fin_reason  = dos_pkg::RSN_FALLBACK;
		rnd_fin_queue  = draw_queue;
		rnd_fin_reason = dos_pkg::RSN_RANDOM;
		if (fb_queue == dos_pkg::Q_BE && mask_q[dos_pkg::Q_NC] && nc_earlier_q) begin
			fb_fin_queue  = dos_pkg::Q_NC;
			fb_fin_reason = dos_pkg::RSN_SWAP;
		end
		if (draw_queue == dos_pkg::Q_BE && mask_q[dos_pkg::Q_NC] && nc_earlier_q) begin
			rnd_fin_queue  = dos_pkg::Q_NC;
			rnd_fin_reason = dos_pkg::RSN_SWAP;
		end
	end

	// Launch a draw on the first try and after every miss short of the limit.
	assign rem_start =
		(state_q == ST_DECIDE && !mask_q[dos_pkg::Q_EF] && !cur_hit && total != '0) ||
		(state_q == ST_DIVIDE && rem_stat.done && !draw_hit && !last_try);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mask_q       <= '0;
			nc_earlier_q <= 1'b0;
			cur_q        <= dos_pkg::NO_QUEUE;
			lfsr_q       <= dos_pkg::LFSR_RESET;
			try_q        <= '0;
			pick_q       <= dos_pkg::NO_QUEUE;
			reason_q     <= dos_pkg::RSN_EF;
			out_valid_q  <= 1'b0;
			out_queue_q  <= dos_pkg::NO_QUEUE;
			out_reason_q <= dos_pkg::RSN_EF;
		end else begin
			// Drop the held result once the sink takes it, unless a new one loads now.
			if (out_valid_q && rsp.ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					// Capture the request; reduce the head times to one compare bit.
					if (req.valid) begin
						mask_q       <= req.nonempty_mask;
						nc_earlier_q <= req.besteffort_head_time > req.netcontrol_head_time;
						state_q      <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (mask_q[dos_pkg::Q_EF]) begin
						pick_q   <= dos_pkg::Q_EF;
						reason_q <= dos_pkg::RSN_EF;
						state_q  <= ST_EMIT;
					end else if (cur_hit) begin
						pick_q   <= cur_q;
						reason_q <= dos_pkg::RSN_CONT;
						state_q  <= ST_EMIT;
					end else begin
						// Current queue drained: forget it before a new pick.
						cur_q <= dos_pkg::NO_QUEUE;
						if (total != '0) begin
							lfsr_q  <= lfsr_nxt;
							try_q   <= '0;
							state_q <= ST_DIVIDE;
						end else if (fb_found) begin
							pick_q   <= fb_fin_queue;
							reason_q <= fb_fin_reason;
							state_q  <= ST_EMIT;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_DIVIDE: begin
					// Hold until the remainder unit reports the draw.
					if (rem_stat.done) begin
						if (draw_hit) begin
							pick_q   <= rnd_fin_queue;
							reason_q <= rnd_fin_reason;
							state_q  <= ST_EMIT;
						end else if (last_try) begin
							if (fb_found) begin
								pick_q   <= fb_fin_queue;
								reason_q <= fb_fin_reason;
								state_q  <= ST_EMIT;
							end else begin
								state_q <= ST_IDLE;
							end
						end else begin
							try_q  <= try_q + 1'b1;
							lfsr_q <= lfsr_nxt;
						end
					end
				end
				ST_EMIT: begin
					// Load the result register when it is free or being emptied.
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_queue_q  <= pick_q;
						out_reason_q <= reason_q;
						// EF service leaves the current queue untouched.
						if (reason_q != dos_pkg::RSN_EF) begin
							cur_q <= pick_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Seed write reloads the LFSR at once; a zero seed loads one.
			if (cfg_wr_en && cfg_index == dos_pkg::REG_RANDOM_SEED) begin
				lfsr_q <= (cfg_data[dos_pkg::LFSR_W-1:0] == '0) ? dos_pkg::LFSR_RESET :
					cfg_data[dos_pkg::LFSR_W-1:0];
			end
		end
	end

	assign req.ready        = state_q == ST_IDLE;
	assign rsp.valid        = out_valid_q;
	assign rsp.served_queue = out_queue_q;
	assign rsp.pick_reason  = out_reason_q;

	a_out_names_queue: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_queue_q != dos_pkg::NO_QUEUE)
		else $error("result names no queue");

	a_ef_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_reason_q == dos_pkg::RSN_EF |-> out_queue_q == dos_pkg::Q_EF)
		else $error("EF priority reason on a non-EF queue");

	a_swap_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_reason_q == dos_pkg::RSN_SWAP |-> out_queue_q == dos_pkg::Q_NC)
		else $error("swap reason on a queue other than NC");

	a_cur_not_ef: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q != dos_pkg::Q_EF)
		else $error("EF became the current queue");

	a_try_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVIDE |-> try_q < dos_pkg::TRY_W'(dos_pkg::MAX_TRIES))
		else $error("draw count beyond the limit");

	a_rem_active: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVIDE |-> rem_stat.busy || rem_stat.done)
		else $error("waiting on an idle remainder unit");

endmodule

// File: rtl/dos_rem.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module dos_rem (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [dos_pkg::LFSR_W-1:0]  dividend,
	input  logic [dos_pkg::CUM_W-1:0]   divisor,
	output logic [dos_pkg::CUM_W-1:0]   remainder,
	output dos_pkg::rem_stat_t          stat
);

	logic                            busy_q;
	logic                            done_q;
	logic [dos_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [dos_pkg::LFSR_W-1:0]      shift_q;
	logic [dos_pkg::CUM_W-1:0]       div_q;
	logic [dos_pkg::CUM_W-1:0]       rem_q;
	logic [dos_pkg::CUM_W:0]         rem_sh;
	logic [dos_pkg::CUM_W:0]         rem_sub;
	logic                            rem_ge;
	logic                            last_step;

	// Bring in the next dividend bit; subtract when the divisor fits.
	assign rem_sh  = {rem_q, shift_q[dos_pkg::LFSR_W-1]};
	assign rem_ge  = rem_sh >= {1'b0, div_q};
	assign rem_sub = rem_sh - {1'b0, div_q};
	assign last_step = cnt_q == dos_pkg::DIV_CNT_W'(dos_pkg::LFSR_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			shift_q <= '0;
			div_q   <= '0;
			rem_q   <= '0;
		end else begin
			done_q <= !start && busy_q && last_step;
			if (start) begin
				busy_q  <= 1'b1;
				cnt_q   <= '0;
				shift_q <= dividend;
				div_q   <= divisor;
				rem_q   <= '0;
			end else if (busy_q) begin
				shift_q <= shift_q << 1;
				rem_q   <= rem_ge ? rem_sub[dos_pkg::CUM_W-1:0] : rem_sh[dos_pkg::CUM_W-1:0];
				cnt_q   <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign remainder = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: rtl/dos_wtab.sv
// Weight registers, cumulative weight table and draw-to-queue mapping.
module dos_wtab (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [dos_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [dos_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [dos_pkg::CUM_W-1:0]        draw,
	output logic [dos_pkg::CUM_W-1:0]        total,
	output logic [dos_pkg::QUEUE_W-1:0]      draw_queue
);

	logic [dos_pkg::WEIGHT_W-1:0] weight_q [dos_pkg::WEIGHTED_QUEUES];
	logic [dos_pkg::CUM_W-1:0]    cum_q    [dos_pkg::WEIGHTED_QUEUES];
	logic [dos_pkg::WQ_IDX_W-1:0] wr_idx;
	logic                         wr_weight;
	logic [dos_pkg::CUM_W-1:0]    delta;

	assign wr_idx    = cfg_index[dos_pkg::WQ_IDX_W-1:0];
	assign wr_weight = cfg_wr_en &&
		(cfg_index < dos_pkg::CFG_INDEX_W'(dos_pkg::WEIGHTED_QUEUES));
	// Change of the written weight; add it to every running sum at or above it.
	assign delta = dos_pkg::CUM_W'(cfg_data[dos_pkg::WEIGHT_W-1:0]) -
		dos_pkg::CUM_W'(weight_q[wr_idx]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dos_pkg::WEIGHTED_QUEUES; i++) begin
				weight_q[i] <= dos_pkg::WEIGHT_RESET[i];
				cum_q[i]    <= dos_pkg::cum_reset(i);
			end
		end else if (wr_weight) begin
			weight_q[wr_idx] <= cfg_data[dos_pkg::WEIGHT_W-1:0];
			for (int i = 0; i < dos_pkg::WEIGHTED_QUEUES; i++) begin
				if (i >= int'(wr_idx)) begin
					cum_q[i] <= cum_q[i] + delta;
				end
			end
		end
	end

	assign total = cum_q[dos_pkg::WEIGHTED_QUEUES-1];

	// First queue whose running sum exceeds the draw; the last one otherwise.
	always_comb begin
		draw_queue = dos_pkg::QUEUE_W'(dos_pkg::WEIGHTED_QUEUES - 1);
		for (int i = dos_pkg::WEIGHTED_QUEUES - 1; i >= 0; i--) begin
			if (draw < cum_q[i]) begin
				draw_queue = dos_pkg::QUEUE_W'(i);
			end
		end
	end

endmodule
